// ===== design/hrbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrbp_pkg
// Shared types and constants of the http request byte parser.
// ----------------------------------------------------------------------------
package hrbp_pkg;

    // field tag of one result
    typedef enum logic [3:0] {
        KIND_METHOD  = 4'd0,
        KIND_PATH    = 4'd1,
        KIND_QUERY   = 4'd2,
        KIND_VERSION = 4'd3,
        KIND_KEY     = 4'd4,
        KIND_VALUE   = 4'd5,
        KIND_BODY    = 4'd6,
        KIND_SEP     = 4'd7,
        KIND_DROP    = 4'd8
    } kind_t;

    // outcome reported on the final result
    typedef enum logic [1:0] {
        STAT_BUSY     = 2'd0,
        STAT_COMPLETE = 2'd1,
        STAT_MALFORM  = 2'd2,
        STAT_LONE_CR  = 2'd3
    } status_t;

    // parser phase, one-hot
    typedef enum logic [8:0] {
        PH_METHOD     = 9'b000000001,
        PH_PATH       = 9'b000000010,
        PH_QUERY      = 9'b000000100,
        PH_VERSION    = 9'b000001000,
        PH_VERSION_LF = 9'b000010000,
        PH_KEY        = 9'b000100000,
        PH_VALUE      = 9'b001000000,
        PH_BODY       = 9'b010000000,
        PH_DROP       = 9'b100000000
    } phase_t;

    // delimiter held back for one byte, one-hot
    typedef enum logic [2:0] {
        HOLD_NONE  = 3'b001,
        HOLD_COLON = 3'b010,
        HOLD_CR    = 3'b100
    } hold_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one tagged byte
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  hdr;
        logic [9:0]  pos;
        logic [7:0]  data;
        status_t     status;
        logic        final_flag;
    } result_t;

    // results caused by one accepted byte
    typedef struct packed {
        logic    two;
        result_t r1;
        result_t r0;
    } entry_t;

    function automatic result_t make_res(kind_t k, logic [3:0] h, logic [9:0] p,
                                         logic [7:0] d);
        result_t r;
        r.kind       = k;
        r.hdr        = h;
        r.pos        = p;
        r.data       = d;
        r.status     = STAT_BUSY;
        r.final_flag = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/http_request_byte_parser_unit.sv =====
// ----------------------------------------------------------------------------
// http_request_byte_parser_unit
// Tags the bytes of an http request with field, header number and position.
// ----------------------------------------------------------------------------
// Input channel: data_byte and end_of_request are taken together at an
// edge with push high and full low; end_of_request marks the last byte.
// Result channel: while empty is low the oldest result sits on field_kind,
// header_number, field_position, byte_out, parse_status and final_result;
// pop high at an edge takes it.
// A byte is classified in the cycle it is accepted and gives zero, one or two
// results; a result passes through the queue and the output register before
// it appears on the outputs. The front accepts one byte per cycle while full
// is low, the output side one result per cycle while pop is high, so a byte
// that gives two results takes two pops. A four-entry queue sits between.
// When pop stays low the queue fills and full rises; results are held and
// none are lost. Reset clears the parser state, the queue and the output
// register; no result is shown until a byte arrives. After the last byte of
// a request the parser returns to its reset state by itself.
// ----------------------------------------------------------------------------
module http_request_byte_parser_unit #(
    parameter int HEADER_LIMIT  = 16,
    parameter int REQUEST_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_request,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  field_kind,
    output logic [3:0]  header_number,
    output logic [9:0]  field_position,
    output logic [7:0]  byte_out,
    output logic [1:0]  parse_status,
    output logic        final_result
);

    logic               accept;
    logic               entry_push;
    hrbp_pkg::entry_t   entry;
    hrbp_pkg::entry_t   q_data;
    logic               q_not_empty;
    logic               q_rd;
    hrbp_pkg::result_t  res;

    assign accept = push && !full;

    // classifier
    hrbp_front #(
        .HEADER_LIMIT  (HEADER_LIMIT),
        .REQUEST_BYTES (REQUEST_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .end_of_request (end_of_request),
        .entry_push     (entry_push),
        .entry          (entry)
    );

    // decoupling queue
    hrbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (entry_push),
        .wr_data   (entry),
        .full      (full),
        .rd_en     (q_rd),
        .rd_data   (q_data),
        .not_empty (q_not_empty)
    );

    // result output
    hrbp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .res         (res)
    );

    assign field_kind     = res.kind;
    assign header_number  = res.hdr;
    assign field_position = res.pos;
    assign byte_out       = res.data;
    assign parse_status   = res.status;
    assign final_result   = res.final_flag;

endmodule

// ===== design/hrbp_front.sv =====
// ----------------------------------------------------------------------------
// hrbp_front
// Classifies each accepted byte and forms the zero, one or two results it
// causes, keeping the parser state.
// ----------------------------------------------------------------------------
module hrbp_front #(
    parameter int HEADER_LIMIT  = 16,
    parameter int REQUEST_BYTES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_request,
    output logic                  entry_push,
    output hrbp_pkg::entry_t      entry
);

    localparam logic [9:0] POS_MAX   = 10'(REQUEST_BYTES - 1);
    localparam logic [4:0] HDR_LIMIT = 5'(HEADER_LIMIT);

    hrbp_pkg::phase_t  phase_reg,  phase_next;
    logic [4:0]        hcount_reg, hcount_next;
    logic [9:0]        pos_reg,    pos_next;
    hrbp_pkg::hold_t   hold_reg,   hold_next;
    logic              lstart_reg, lstart_next;
    hrbp_pkg::status_t term_reg,   term_next;

    hrbp_pkg::result_t res [2];
    logic [1:0]        n;

    // header index capped at 15
    function automatic logic [3:0] hdr_of(logic [4:0] c);
        return (c > 5'd15) ? 4'd15 : c[3:0];
    endfunction

    // classification of one byte
    always_comb
    begin
        logic              hb;
        logic              last;
        logic [7:0]        b;
        logic [9:0]        p;
        hrbp_pkg::status_t st;

        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        lstart_next = lstart_reg;
        term_next   = term_reg;
        res[0]      = '0;
        res[1]      = '0;
        n           = 2'd0;
        hb          = 1'b0;
        last        = end_of_request;
        b           = data_byte;
        p           = '0;
        st          = hrbp_pkg::STAT_BUSY;

        unique case (hold_reg)
            hrbp_pkg::HOLD_COLON:
            begin
                hold_next = hrbp_pkg::HOLD_NONE;
                if (b == hrbp_pkg::CH_SPACE)
                begin
                    res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, hdr_of(hcount_next),
                                                10'd0, hrbp_pkg::CH_COLON);
                    res[1] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, hdr_of(hcount_next),
                                                10'd0, b);
                    n          = 2'd2;
                    phase_next = hrbp_pkg::PH_VALUE;
                    pos_next   = '0;
                end
                else
                begin
                    p = pos_next;
                    if (pos_next < POS_MAX)
                        pos_next = pos_next + 10'd1;
                    res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_KEY, hdr_of(hcount_next),
                                                p, hrbp_pkg::CH_COLON);
                    n  = 2'd1;
                    hb = 1'b1;
                end
            end
            hrbp_pkg::HOLD_CR:
            begin
                hold_next = hrbp_pkg::HOLD_NONE;
                if (b == hrbp_pkg::CH_LF)
                begin
                    res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, hdr_of(hcount_next),
                                                10'd0, hrbp_pkg::CH_CR);
                    res[1] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, hdr_of(hcount_next),
                                                10'd0, b);
                    n = 2'd2;
                    if (lstart_reg)
                        phase_next = hrbp_pkg::PH_BODY;
                    else
                    begin
                        if (hcount_next < HDR_LIMIT)
                            hcount_next = hcount_next + 5'd1;
                        phase_next = hrbp_pkg::PH_KEY;
                    end
                    pos_next    = '0;
                    lstart_next = 1'b1;
                end
                else
                begin
                    res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_DROP, 4'd0, 10'd0,
                                                hrbp_pkg::CH_CR);
                    res[1] = hrbp_pkg::make_res(hrbp_pkg::KIND_DROP, 4'd0, 10'd0, b);
                    n          = 2'd2;
                    phase_next = hrbp_pkg::PH_DROP;
                    term_next  = hrbp_pkg::STAT_LONE_CR;
                end
            end
            hrbp_pkg::HOLD_NONE:
            begin
                unique case (phase_reg)
                    hrbp_pkg::PH_METHOD:
                    begin
                        n = 2'd1;
                        if (b == hrbp_pkg::CH_SPACE)
                        begin
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, 4'd0, 10'd0, b);
                            phase_next = hrbp_pkg::PH_PATH;
                            pos_next   = '0;
                        end
                        else
                        begin
                            p = pos_next;
                            if (pos_next < POS_MAX)
                                pos_next = pos_next + 10'd1;
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_METHOD, 4'd0, p, b);
                        end
                    end
                    hrbp_pkg::PH_PATH, hrbp_pkg::PH_QUERY:
                    begin
                        n = 2'd1;
                        if (b == hrbp_pkg::CH_SPACE)
                        begin
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, 4'd0, 10'd0, b);
                            phase_next = hrbp_pkg::PH_VERSION;
                            pos_next   = '0;
                        end
                        else if (phase_reg == hrbp_pkg::PH_PATH && b == hrbp_pkg::CH_QMARK)
                        begin
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, 4'd0, 10'd0, b);
                            phase_next = hrbp_pkg::PH_QUERY;
                            pos_next   = '0;
                        end
                        else
                        begin
                            p = pos_next;
                            if (pos_next < POS_MAX)
                                pos_next = pos_next + 10'd1;
                            res[0] = hrbp_pkg::make_res(
                                (phase_reg == hrbp_pkg::PH_PATH) ? hrbp_pkg::KIND_PATH
                                                                 : hrbp_pkg::KIND_QUERY,
                                4'd0, p, b);
                        end
                    end
                    hrbp_pkg::PH_VERSION:
                    begin
                        n = 2'd1;
                        if (b == hrbp_pkg::CH_CR)
                        begin
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, 4'd0, 10'd0, b);
                            phase_next = hrbp_pkg::PH_VERSION_LF;
                        end
                        else
                        begin
                            p = pos_next;
                            if (pos_next < POS_MAX)
                                pos_next = pos_next + 10'd1;
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_VERSION, 4'd0, p, b);
                        end
                    end
                    hrbp_pkg::PH_VERSION_LF:
                    begin
                        n = 2'd1;
                        if (b == hrbp_pkg::CH_LF)
                        begin
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_SEP, 4'd0, 10'd0, b);
                            phase_next  = hrbp_pkg::PH_KEY;
                            hcount_next = '0;
                            pos_next    = '0;
                            lstart_next = 1'b1;
                        end
                        else
                        begin
                            res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_DROP, 4'd0, 10'd0, b);
                            phase_next = hrbp_pkg::PH_DROP;
                            term_next  = hrbp_pkg::STAT_MALFORM;
                        end
                    end
                    hrbp_pkg::PH_KEY, hrbp_pkg::PH_VALUE:
                    begin
                        hb = 1'b1;
                    end
                    hrbp_pkg::PH_BODY:
                    begin
                        n = 2'd1;
                        p = pos_next;
                        if (pos_next < POS_MAX)
                            pos_next = pos_next + 10'd1;
                        res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_BODY, 4'd0, p, b);
                    end
                    default:
                    begin
                        n = 2'd1;
                        res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_DROP, 4'd0, 10'd0, b);
                    end
                endcase
            end
            default:
            begin
                hold_next = hrbp_pkg::HOLD_NONE;
            end
        endcase

        // byte inside a header line
        if (hb)
        begin
            if (b == hrbp_pkg::CH_CR)
            begin
                if (last)
                begin
                    res[n[0]] = hrbp_pkg::make_res(hrbp_pkg::KIND_DROP, 4'd0, 10'd0, b);
                    n          = n + 2'd1;
                    phase_next = hrbp_pkg::PH_DROP;
                    term_next  = hrbp_pkg::STAT_LONE_CR;
                    hold_next  = hrbp_pkg::HOLD_NONE;
                end
                else
                    hold_next = hrbp_pkg::HOLD_CR;
            end
            else
            begin
                lstart_next = 1'b0;
                if (hcount_next >= HDR_LIMIT)
                begin
                    res[n[0]] = hrbp_pkg::make_res(hrbp_pkg::KIND_DROP, hdr_of(hcount_next),
                                                   10'd0, b);
                    n = n + 2'd1;
                end
                else if (phase_next == hrbp_pkg::PH_KEY && b == hrbp_pkg::CH_COLON && !last)
                    hold_next = hrbp_pkg::HOLD_COLON;
                else
                begin
                    p = pos_next;
                    if (pos_next < POS_MAX)
                        pos_next = pos_next + 10'd1;
                    res[n[0]] = hrbp_pkg::make_res(
                        (phase_next == hrbp_pkg::PH_KEY) ? hrbp_pkg::KIND_KEY
                                                         : hrbp_pkg::KIND_VALUE,
                        hdr_of(hcount_next), p, b);
                    n = n + 2'd1;
                end
            end
        end

        // outcome on the last byte of a request
        if (last)
        begin
            if (n == 2'd0)
            begin
                res[0] = hrbp_pkg::make_res(hrbp_pkg::KIND_DROP, 4'd0, 10'd0, b);
                n      = 2'd1;
            end
            if (term_next != hrbp_pkg::STAT_BUSY)
                st = term_next;
            else if (phase_next == hrbp_pkg::PH_METHOD || phase_next == hrbp_pkg::PH_PATH ||
                     phase_next == hrbp_pkg::PH_QUERY || phase_next == hrbp_pkg::PH_VERSION ||
                     phase_next == hrbp_pkg::PH_VERSION_LF)
                st = hrbp_pkg::STAT_MALFORM;
            else
                st = hrbp_pkg::STAT_COMPLETE;
            if (n == 2'd2)
            begin
                res[1].status     = st;
                res[1].final_flag = 1'b1;
            end
            else
            begin
                res[0].status     = st;
                res[0].final_flag = 1'b1;
            end
            phase_next  = hrbp_pkg::PH_METHOD;
            hcount_next = '0;
            pos_next    = '0;
            hold_next   = hrbp_pkg::HOLD_NONE;
            lstart_next = 1'b0;
            term_next   = hrbp_pkg::STAT_BUSY;
        end
    end

    // entry toward the queue
    assign entry_push = accept && (n != 2'd0);
    assign entry.two  = (n == 2'd2);
    assign entry.r0   = res[0];
    assign entry.r1   = res[1];

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrbp_pkg::PH_METHOD;
            hcount_reg <= '0;
            pos_reg    <= '0;
            hold_reg   <= hrbp_pkg::HOLD_NONE;
            lstart_reg <= 1'b0;
            term_reg   <= hrbp_pkg::STAT_BUSY;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            pos_reg    <= pos_next;
            hold_reg   <= hold_next;
            lstart_reg <= lstart_next;
            term_reg   <= term_next;
        end
    end

endmodule

// ===== design/hrbp_queue.sv =====
// ----------------------------------------------------------------------------
// hrbp_queue
// Short queue of result entries between the classifier and the output side.
// ----------------------------------------------------------------------------
module hrbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  hrbp_pkg::entry_t  wr_data,
    output logic              full,
    input  logic              rd_en,
    output hrbp_pkg::entry_t  rd_data,
    output logic              not_empty
);

    localparam int PW = hrbp_pkg::QPTR_W;

    hrbp_pkg::entry_t  mem [hrbp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wptr_reg, wptr_next;
    logic [PW-1:0]     rptr_reg, rptr_next;
    logic [PW:0]       count_reg, count_next;
    logic              do_wr, do_rd;

    assign full      = (count_reg == (PW+1)'(hrbp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + PW'(1) : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + PW'(1) : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (PW+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (PW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wr_data;
    end

endmodule

// ===== design/hrbp_back.sv =====
// ----------------------------------------------------------------------------
// hrbp_back
// Output register: takes entries from the queue and hands out their results
// one result at a time.
// ----------------------------------------------------------------------------
module hrbp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  hrbp_pkg::entry_t   q_data,
    output logic               q_rd,
    input  logic               pop,
    output logic               empty,
    output hrbp_pkg::result_t  res
);

    hrbp_pkg::entry_t  cur_reg,   cur_next;
    logic              valid_reg, valid_next;
    logic              idx_reg,   idx_next;
    logic              taken, last_of_entry, advance;

    assign empty         = !valid_reg;
    assign taken         = pop && valid_reg;
    assign last_of_entry = idx_reg || !cur_reg.two;
    assign advance       = !valid_reg || (taken && last_of_entry);
    assign q_rd          = advance && q_not_empty;
    assign res           = idx_reg ? cur_reg.r1 : cur_reg.r0;

    // select next entry or second result
    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (advance)
        begin
            cur_next   = q_data;
            valid_next = q_not_empty;
            idx_next   = 1'b0;
        end
        else if (taken)
            idx_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ===== design/hrbp_checker.sv =====
// ----------------------------------------------------------------------------
// hrbp_checker
// Port-level checks of the http request byte parser.
// ----------------------------------------------------------------------------
module hrbp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  field_kind,
    input  logic [3:0]  header_number,
    input  logic [9:0]  field_position,
    input  logic [7:0]  byte_out,
    input  logic [1:0]  parse_status,
    input  logic        final_result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(field_kind) && $stable(header_number) &&
                              $stable(field_position) && $stable(byte_out) &&
                              $stable(parse_status) && $stable(final_result)))
    else $error("stalled result changed");

    // outcome shows exactly on the final result
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (final_result == (parse_status != 2'(hrbp_pkg::STAT_BUSY))))
    else $error("status and final flag disagree");

    // separators and dropped bytes carry no position
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (field_kind == 4'(hrbp_pkg::KIND_SEP) ||
                    field_kind == 4'(hrbp_pkg::KIND_DROP))) |-> (field_position == '0))
    else $error("nonzero position on separator or dropped byte");

    // request line and body have no header number
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (field_kind == 4'(hrbp_pkg::KIND_METHOD) ||
                    field_kind == 4'(hrbp_pkg::KIND_PATH) ||
                    field_kind == 4'(hrbp_pkg::KIND_QUERY) ||
                    field_kind == 4'(hrbp_pkg::KIND_VERSION) ||
                    field_kind == 4'(hrbp_pkg::KIND_BODY))) |-> (header_number == '0))
    else $error("header number outside headers");

endmodule

bind http_request_byte_parser_unit hrbp_checker u_hrbp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .field_kind     (field_kind),
    .header_number  (header_number),
    .field_position (field_position),
    .byte_out       (byte_out),
    .parse_status   (parse_status),
    .final_result   (final_result)
);
